/* rtl/tama_pkg.sv */
// shared constants and types for the three-axis moving average unit
`timescale 1ns / 1ps
`default_nettype none
package tama_pkg;

	localparam int DATA_W     = 32;
	localparam int AXES       = 3;
	localparam int COUNT_W    = 3;
	localparam int WINDOW_DEF = 5;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

/* rtl/three_axis_moving_average_unit.sv */
// top level of the three-axis moving average unit
`timescale 1ns / 1ps
`default_nettype none
// Takes one (x, y, z) request and returns the per-axis mean of the last
// WINDOW samples, truncated toward zero, with the number of samples used.
// The ring of samples sits in one ram of three 32-bit lanes; a request is
// read, updated and written back in order, so no forwarding is needed.
// The mean is formed by three bit-serial dividers, one bit a cycle, on
// sums of SUM_W = 32 + clog2(WINDOW) bits. The next request is taken as
// soon as the result has moved to the output register, while it waits to
// be taken, so the unit takes no new request while a division runs.
module three_axis_moving_average_unit #(
	parameter int WINDOW = tama_pkg::WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic signed [tama_pkg::DATA_W-1:0]  x_sample,
	input  logic signed [tama_pkg::DATA_W-1:0]  y_sample,
	input  logic signed [tama_pkg::DATA_W-1:0]  z_sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [tama_pkg::DATA_W-1:0]  avg_x,
	output logic signed [tama_pkg::DATA_W-1:0]  avg_y,
	output logic signed [tama_pkg::DATA_W-1:0]  avg_z,
	output logic [tama_pkg::COUNT_W-1:0]        fill_count
);
	import tama_pkg::*;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = DATA_W + $clog2(WINDOW);
	localparam int ROW_W  = AXES * DATA_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;

	logic [2:0]              state_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [CNT_W-1:0]        filled_q;
	logic signed [SUM_W-1:0] sum_q [AXES];
	logic signed [DATA_W-1:0] samp_q [AXES];
	logic [ROW_W-1:0]        rd_row;
	logic [ROW_W-1:0]        wr_row;
	logic                    full;
	logic                    accept;
	logic                    ram_we;
	logic                    div_start;
	logic [DATA_W-1:0]       quot [AXES];
	div_stat_t               stat [AXES];
	logic                    all_done;
	logic                    load_out;
	logic signed [SUM_W-1:0] next_sum [AXES];

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign full         = (filled_q == CNT_W'(WINDOW));
	assign ram_we       = (state_q == ST_READ);
	assign div_start    = (state_q == ST_START);
	assign all_done     = stat[0].done && stat[1].done && stat[2].done;
	assign load_out     = (state_q == ST_WAIT) && all_done && (!result_valid || result_ready);
	assign wr_row       = {samp_q[2], samp_q[1], samp_q[0]};

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			next_sum[a] = sum_q[a] + SUM_W'(samp_q[a]);
			if (full) begin
				next_sum[a] = next_sum[a]
					- SUM_W'($signed(rd_row[a*DATA_W +: DATA_W]));
			end
		end
	end

	tama_ram #(
		.WIDTH (ROW_W),
		.DEPTH (WINDOW),
		.AW    (SLOT_W)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (wr_row),
		.raddr (slot_q),
		.rdata (rd_row)
	);

	for (genvar g = 0; g < AXES; g++) begin : g_div
		tama_div #(
			.SUM_W (SUM_W),
			.CNT_W (CNT_W)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (sum_q[g]),
			.divisor  (filled_q),
			.stat     (stat[g]),
			.quotient (quot[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_q       <= '0;
			filled_q     <= '0;
			result_valid <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else begin
			if (load_out) begin
				result_valid <= 1'b1;
			end else if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					for (int a = 0; a < AXES; a++) begin
						sum_q[a] <= next_sum[a];
					end
					slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
					if (!full) begin
						filled_q <= filled_q + CNT_W'(1);
					end
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samp_q[0] <= x_sample;
			samp_q[1] <= y_sample;
			samp_q[2] <= z_sample;
		end
		if (load_out) begin
			avg_x      <= quot[0];
			avg_y      <= quot[1];
			avg_z      <= quot[2];
			fill_count <= COUNT_W'(filled_q);
		end
	end

endmodule
`default_nettype wire

/* rtl/tama_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tama_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/tama_div.sv */
// bit-serial signed divider, truncating toward zero, small unsigned divisor
`timescale 1ns / 1ps
`default_nettype none
module tama_div #(
	parameter int SUM_W = 35,
	parameter int CNT_W = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output tama_pkg::div_stat_t     stat,
	output logic [tama_pkg::DATA_W-1:0] quotient
);
	import tama_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [SUM_W-1:0]  mag_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    trial;
	logic              fits;
	logic [CNT_W:0]    diff;
	logic [SUM_W-1:0]  signed_q;

	assign trial = {rem_q, mag_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? -dividend : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign signed_q  = neg_q ? -mag_q : mag_q;
	assign quotient  = signed_q[DATA_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

/* tb/tb.sv */
// testbench for the three-axis moving average unit
`timescale 1ns / 1ps
module tb;
	import tama_pkg::*;

	localparam int WINDOW     = WINDOW_DEF;
	localparam int QUIET_MAX  = 2000;
	localparam int DRAIN_WAIT = 60;

	typedef logic signed [DATA_W-1:0] coord_t;

	typedef struct {
		coord_t               mean_x;
		coord_t               mean_y;
		coord_t               mean_z;
		logic [COUNT_W-1:0]   used;
	} window_mean_t;

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_ready;
	coord_t             x_sample;
	coord_t             y_sample;
	coord_t             z_sample;
	logic               result_valid;
	logic               result_ready;
	coord_t             avg_x;
	coord_t             avg_y;
	coord_t             avg_z;
	logic [COUNT_W-1:0] fill_count;

	// own copy of the filter state
	coord_t       win_samples [AXES][WINDOW];
	longint       win_sums [AXES];
	int unsigned  win_slot;
	int unsigned  win_count;

	window_mean_t pending_means [$];
	window_mean_t want;
	int           errors;
	int           quiet_cycles;
	bit           steady;
	int           stall_left;

	three_axis_moving_average_unit #(
		.WINDOW(WINDOW)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.x_sample     (x_sample),
		.y_sample     (y_sample),
		.z_sample     (z_sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.avg_x        (avg_x),
		.avg_y        (avg_y),
		.avg_z        (avg_z),
		.fill_count   (fill_count)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		x_sample     = '0;
		y_sample     = '0;
		z_sample     = '0;
		result_ready = 1'b0;
		errors       = 0;
		quiet_cycles = 0;
		steady       = 1'b0;
		stall_left   = 0;
		win_slot     = 0;
		win_count    = 0;
		for (int a = 0; a < AXES; a++) begin
			win_sums[a] = 0;
			for (int i = 0; i < WINDOW; i++)
				win_samples[a][i] = '0;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 70);
	endfunction

	function automatic coord_t pick_coord();
		int r;
		r = $urandom_range(0, 11);
		case (r)
			0, 1, 2, 3: return coord_t'($urandom);
			4, 5:       return coord_t'($urandom_range(0, 32)) - 16;
			6:          return 32'sh7fff_ffff - coord_t'($urandom_range(0, 3));
			7:          return 32'sh8000_0000 + coord_t'($urandom_range(0, 3));
			8:          return coord_t'($urandom) >>> $urandom_range(8, 28);
			default:    return coord_t'($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	// running sum over the ring, mean truncated toward zero
	function automatic void predict_window_mean(coord_t x, coord_t y, coord_t z);
		coord_t       fresh [AXES];
		longint       mean;
		window_mean_t m;
		bit           full;
		fresh[0] = x;
		fresh[1] = y;
		fresh[2] = z;
		full = (win_count >= WINDOW);
		for (int a = 0; a < AXES; a++) begin
			if (full)
				win_sums[a] -= longint'(win_samples[a][win_slot]);
			win_samples[a][win_slot] = fresh[a];
			win_sums[a] += longint'(fresh[a]);
		end
		win_slot = (win_slot + 1) % WINDOW;
		if (!full)
			win_count++;
		mean = win_sums[0] / longint'(win_count);
		m.mean_x = mean[DATA_W-1:0];
		mean = win_sums[1] / longint'(win_count);
		m.mean_y = mean[DATA_W-1:0];
		mean = win_sums[2] / longint'(win_count);
		m.mean_z = mean[DATA_W-1:0];
		m.used = win_count[COUNT_W-1:0];
		pending_means.push_back(m);
	endfunction

	task automatic report_error(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		errors++;
	endtask

	// entered and left at a falling edge
	task automatic send_sample(input coord_t x, input coord_t y, input coord_t z);
		int gap;
		sample_valid <= 1'b1;
		x_sample     <= x;
		y_sample     <= y;
		z_sample     <= z;
		do
			@(posedge clk);
		while (!sample_ready);
		predict_window_mean(x, y, z);
		@(negedge clk);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// partly filled ring, wrap-round, truncation of negative means
	task automatic test_fill_and_wrap();
		send_sample(-7, 3, 0);
		send_sample(4, -4, -1);
		send_sample(10, 2, -1);
		send_sample(-20, -9, 5);
		send_sample(1, 1, -6);
		send_sample(100, -100, 13);
		send_sample(-100, 100, -13);
	endtask

	// running sums at their widest, both signs
	task automatic test_extremes();
		repeat (6) send_sample(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		repeat (6) send_sample(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
		send_sample(32'sh7fff_ffff, 32'sh8000_0000, -1);
		send_sample(-1, 32'sh7fff_ffff, 32'sh8000_0000);
		send_sample(0, 0, 32'sh7fff_ffff);
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) send_sample(pick_coord(), pick_coord(), pick_coord());
	endtask

	task automatic test_back_to_back(input int count);
		steady = 1'b1;
		repeat (count) send_sample(pick_coord(), pick_coord(), pick_coord());
		steady = 1'b0;
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_fill_and_wrap();
		test_extremes();
		test_random_traffic(700);
		test_back_to_back(200);
		test_random_traffic(630);
		sample_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// result side back-pressure
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !steady) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				stall_left = 0;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_means.size() == 0) begin
				report_error("result with no request pending");
			end else begin
				want = pending_means.pop_front();
				if (avg_x !== want.mean_x)
					report_error($sformatf("avg_x expected %0d got %0d", want.mean_x, avg_x));
				if (avg_y !== want.mean_y)
					report_error($sformatf("avg_y expected %0d got %0d", want.mean_y, avg_y));
				if (avg_z !== want.mean_z)
					report_error($sformatf("avg_z expected %0d got %0d", want.mean_z, avg_z));
				if (fill_count !== want.used)
					report_error($sformatf("fill_count expected %0d got %0d",
						want.used, fill_count));
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule
